// ===== rtl/core/tsar_pkg.sv =====
// Shared types, codes and constants for the temperature sensor register block.
// Used by the alert evaluator, the top level and the testbench.
package tsar_pkg;

  // Item codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_SAMPLE     = 3'd0,
    MODE_START_READ = 3'd1,
    MODE_BUS_EVENT  = 3'd2,
    MODE_WRITE      = 3'd3,
    MODE_READ       = 3'd4
  } mode_e;

  // Register pointer codes
  typedef enum logic [1:0] {
    PTR_TEMP   = 2'd0,
    PTR_CONFIG = 2'd1,
    PTR_LOW    = 2'd2,
    PTR_HIGH   = 2'd3
  } ptr_e;

  // Config word bit positions
  localparam int unsigned CfgOsBit  = 15;
  localparam int unsigned CfgPolBit = 10;
  localparam int unsigned CfgTmBit  = 9;
  localparam int unsigned CfgSdBit  = 8;
  localparam int unsigned CfgAlBit  = 5;
  localparam int unsigned CfgEmBit  = 4;

  localparam logic [15:0] CfgRoMask = 16'h6020;
  localparam logic [15:0] CfgWrMask = 16'h1FD0;
  localparam logic [15:0] CfgReset  = 16'h60A0;
  localparam logic [15:0] LowReset  = 16'h4B00;
  localparam logic [15:0] HighReset = 16'h5000;
  localparam logic [7:0]  ReadPad   = 8'hFF;

  // Alert state that the evaluator updates
  typedef struct packed {
    logic       alert;
    logic       watch_falling;
    logic [2:0] high_cnt;
    logic [2:0] low_cnt;
  } alert_state_t;

  // Fault queue depth from the F1..F0 field
  function automatic logic [2:0] queue_depth(input logic [1:0] fq);
    logic [2:0] d;
    unique case (fq)
      2'd0: d = 3'd1;
      2'd1: d = 3'd2;
      2'd2: d = 3'd4;
      default: d = 3'd6;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/tsar_if.sv =====
// Valid/ready channel interfaces for input items and result words.
// Depends on nothing but plain logic types.
interface tsar_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [11:0] sample_temp;
  logic [7:0]  data_byte;

  modport source (output valid, output mode, output sample_temp, output data_byte,
                  input ready);
  modport sink (input valid, input mode, input sample_temp, input data_byte,
                output ready);
endinterface

interface tsar_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       alert_pin;

  modport source (output valid, output read_data, output alert_pin, input ready);
  modport sink (input valid, input read_data, input alert_pin, output ready);
endinterface

// ===== rtl/core/tsar_eval.sv =====
// Alert evaluation: limit decode, fault queue counting, comparator and interrupt modes.
// Uses tsar_pkg for the alert state struct, config bit positions and queue depth.
module tsar_eval (
  input  logic [15:0]                cfg_i,
  input  logic signed [12:0]         temp_i,
  input  logic [15:0]                low_lim_i,
  input  logic [15:0]                high_lim_i,
  input  logic                       os_req_i,
  input  tsar_pkg::alert_state_t     state_i,
  output tsar_pkg::alert_state_t     state_o
);

  logic signed [12:0] low_val, high_val;
  logic               em, sd, tm;
  logic               hi_hit, lo_hit;
  logic [2:0]         depth, high_inc, low_inc;

  assign em = cfg_i[tsar_pkg::CfgEmBit];
  assign sd = cfg_i[tsar_pkg::CfgSdBit];
  assign tm = cfg_i[tsar_pkg::CfgTmBit];

  // Extended format keeps 13 bits, normal keeps 12 sign-extended
  assign low_val  = em ? $signed(low_lim_i[15:3])
                       : $signed({low_lim_i[15], low_lim_i[15:4]});
  assign high_val = em ? $signed(high_lim_i[15:3])
                       : $signed({high_lim_i[15], high_lim_i[15:4]});

  assign hi_hit   = temp_i >= high_val;
  assign lo_hit   = temp_i < low_val;
  assign depth    = tsar_pkg::queue_depth(cfg_i[12:11]);
  assign high_inc = state_i.high_cnt + 3'd1;
  assign low_inc  = state_i.low_cnt + 3'd1;

  always_comb begin
    state_o = state_i;
    if (sd && !os_req_i) begin
      state_o.high_cnt = '0;
      state_o.low_cnt  = '0;
    end else if (tm) begin
      // Interrupt mode: hold while the alert is latched
      if (!state_i.alert) begin
        if (state_i.watch_falling) begin
          state_o.high_cnt = '0;
          state_o.low_cnt  = lo_hit ? low_inc : 3'd0;
          if (lo_hit && low_inc >= depth) begin
            state_o.alert         = 1'b1;
            state_o.watch_falling = 1'b0;
            state_o.high_cnt      = '0;
            state_o.low_cnt       = '0;
          end
        end else begin
          state_o.low_cnt  = '0;
          state_o.high_cnt = hi_hit ? high_inc : 3'd0;
          if (hi_hit && high_inc >= depth) begin
            state_o.alert         = 1'b1;
            state_o.watch_falling = 1'b1;
            state_o.high_cnt      = '0;
            state_o.low_cnt       = '0;
          end
        end
      end
    end else begin
      if (state_i.alert) begin
        state_o.high_cnt = '0;
        state_o.low_cnt  = lo_hit ? low_inc : 3'd0;
        if (lo_hit && low_inc >= depth) begin
          state_o.alert    = 1'b0;
          state_o.high_cnt = '0;
          state_o.low_cnt  = '0;
        end
      end else begin
        state_o.low_cnt  = '0;
        state_o.high_cnt = hi_hit ? high_inc : 3'd0;
        if (hi_hit && high_inc >= depth) begin
          state_o.alert    = 1'b1;
          state_o.high_cnt = '0;
          state_o.low_cnt  = '0;
        end
      end
    end
  end

endmodule

// ===== rtl/core/temp_sensor_alert_regs.sv =====
// Top level of the temperature sensor register block: register file, bus byte
// handling and result register. Uses tsar_pkg, tsar_if and tsar_eval.
//
// Usage: items arrive on in_i (valid/ready): a new sample, a start of read,
// any other bus event, a written byte or a read byte. Every accepted item
// produces exactly one result word on out_o: the read byte (0 for items
// other than a read byte, 0xFF past the second byte) and the alert pin level
// after the item, polarity applied.
// Latency: the result word is valid the cycle after the item is accepted.
// Throughput: one item per cycle while the receiver keeps up; all work for an item is one pass of
// combinational logic from the state registers into the result register.
// Stall: in_i.ready is high while the result register is empty or its word is
// being taken, so a stalled receiver holds at most one pending word and
// back-pressures the input until it drains.
// Reset (rst_ni low, asynchronous): pointer at the temperature register,
// config 0x60A0, low limit 0x4B00, high limit 0x5000, temperature, counts and
// alert state cleared, result register empty.
module temp_sensor_alert_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsar_in_if.sink     in_i,
  tsar_out_if.source  out_o
);

  logic [1:0]             ptr_q, ptr_d;
  logic [7:0]             cnt_q, cnt_d;
  logic [7:0]             buf0_q, buf0_d, buf1_q, buf1_d;
  logic [15:0]            cfg_q, cfg_d;
  logic [15:0]            low_q, low_d, high_q, high_d;
  logic [12:0]            temp_q, temp_d;
  tsar_pkg::alert_state_t st_q, st_d;
  logic                   out_valid_q;
  logic [7:0]             rd_q, rd_d;
  logic                   pin_q, pin_d;

  logic                   accept;
  logic [15:0]            wr_word, cfg_wr, rd_word;
  logic                   os_req;
  logic [15:0]            ev_cfg;
  logic signed [12:0]     ev_temp;
  tsar_pkg::alert_state_t ev_in, ev_out;
  logic                   pin_now;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign wr_word = {buf0_q, in_i.data_byte};
  assign cfg_wr  = (cfg_q & tsar_pkg::CfgRoMask) | (wr_word & tsar_pkg::CfgWrMask);

  tsar_eval u_eval (
    .cfg_i      (ev_cfg),
    .temp_i     (ev_temp),
    .low_lim_i  (low_q),
    .high_lim_i (high_q),
    .os_req_i   (os_req),
    .state_i    (ev_in),
    .state_o    (ev_out)
  );

  always_comb begin
    ptr_d    = ptr_q;
    cnt_d    = cnt_q;
    buf0_d   = buf0_q;
    buf1_d   = buf1_q;
    cfg_d    = cfg_q;
    low_d    = low_q;
    high_d   = high_q;
    temp_d   = temp_q;
    st_d     = st_q;
    rd_d     = 8'd0;
    os_req   = 1'b0;
    ev_cfg   = cfg_q;
    ev_temp  = $signed(temp_q);
    ev_in    = st_q;
    pin_now  = st_q.alert ^ ~cfg_q[tsar_pkg::CfgPolBit];
    rd_word  = '0;

    unique case (in_i.mode)
      tsar_pkg::MODE_SAMPLE: begin
        temp_d  = {in_i.sample_temp[11], in_i.sample_temp};
        ev_temp = $signed({in_i.sample_temp[11], in_i.sample_temp});
        st_d    = ev_out;
      end
      tsar_pkg::MODE_START_READ: begin
        cnt_d = 8'd0;
        if (cfg_q[tsar_pkg::CfgTmBit]) begin
          st_d.alert    = 1'b0;
          st_d.high_cnt = '0;
          st_d.low_cnt  = '0;
        end
        pin_now = st_d.alert ^ ~cfg_q[tsar_pkg::CfgPolBit];
        unique case (tsar_pkg::ptr_e'(ptr_q))
          tsar_pkg::PTR_TEMP: begin
            rd_word = cfg_q[tsar_pkg::CfgEmBit] ? {temp_q, 3'b001} : {temp_q[11:0], 4'b0000};
          end
          tsar_pkg::PTR_CONFIG: begin
            rd_word = cfg_q;
            rd_word[tsar_pkg::CfgAlBit] = pin_now;
          end
          tsar_pkg::PTR_LOW:  rd_word = low_q;
          tsar_pkg::PTR_HIGH: rd_word = high_q;
          default:            rd_word = high_q;
        endcase
        buf0_d = rd_word[15:8];
        buf1_d = rd_word[7:0];
      end
      tsar_pkg::MODE_BUS_EVENT: begin
        cnt_d = 8'd0;
      end
      tsar_pkg::MODE_WRITE: begin
        cnt_d = cnt_q + 8'd1;
        if (cnt_q == 8'd0) begin
          ptr_d = in_i.data_byte[1:0];
        end else if (cnt_q == 8'd1) begin
          buf0_d = in_i.data_byte;
        end else if (cnt_q == 8'd2) begin
          buf1_d = in_i.data_byte;
          // Second data byte commits; writes to the temperature register drop
          if (tsar_pkg::ptr_e'(ptr_q) != tsar_pkg::PTR_TEMP) begin
            st_d.high_cnt = '0;
            st_d.low_cnt  = '0;
          end
          unique case (tsar_pkg::ptr_e'(ptr_q))
            tsar_pkg::PTR_TEMP: ;
            tsar_pkg::PTR_CONFIG: begin
              cfg_d = cfg_wr;
              if (cfg_wr[tsar_pkg::CfgSdBit] && cfg_wr[tsar_pkg::CfgTmBit]
                  && !cfg_q[tsar_pkg::CfgSdBit]) begin
                st_d.alert = 1'b0;
              end
              os_req = cfg_wr[tsar_pkg::CfgSdBit] && wr_word[tsar_pkg::CfgOsBit];
            end
            tsar_pkg::PTR_LOW:  low_d  = wr_word;
            tsar_pkg::PTR_HIGH: high_d = wr_word;
            default:            high_d = wr_word;
          endcase
          if (os_req) begin
            ev_cfg = cfg_wr;
            ev_in  = st_d;
            st_d   = ev_out;
          end
        end
      end
      tsar_pkg::MODE_READ: begin
        if (cnt_q < 8'd2) begin
          rd_d  = cnt_q[0] ? buf1_q : buf0_q;
          cnt_d = cnt_q + 8'd1;
        end else begin
          rd_d = tsar_pkg::ReadPad;
        end
      end
      default: ;
    endcase

    pin_d = st_d.alert ^ ~cfg_d[tsar_pkg::CfgPolBit];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      cnt_q       <= '0;
      buf0_q      <= '0;
      buf1_q      <= '0;
      cfg_q       <= tsar_pkg::CfgReset;
      low_q       <= tsar_pkg::LowReset;
      high_q      <= tsar_pkg::HighReset;
      temp_q      <= '0;
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        ptr_q  <= ptr_d;
        cnt_q  <= cnt_d;
        buf0_q <= buf0_d;
        buf1_q <= buf1_d;
        cfg_q  <= cfg_d;
        low_q  <= low_d;
        high_q <= high_d;
        temp_q <= temp_d;
        st_q   <= st_d;
      end
      if (in_i.ready) begin
        out_valid_q <= accept;
      end
    end
  end

  // Result word payload; loads only with a new word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q  <= rd_d;
      pin_q <= pin_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = rd_q;
  assign out_o.alert_pin = pin_q;

endmodule

// ===== test/tb_temp_sensor_alert_regs.sv =====
// Testbench for temp_sensor_alert_regs: drives sample and bus items, predicts every result
// word with a local model of the registers and alert logic, and checks each word in order.
// Depends on tsar_pkg, tsar_if and the block itself.
module tb_temp_sensor_alert_regs;
  import tsar_pkg::*;

  localparam logic [2:0]  ModeSpareFirst = 3'd5;
  localparam logic [2:0]  ModeSpareLast  = 3'd7;
  localparam int unsigned CfgFqLsb       = 11;
  localparam int          IdlePct        = 13;
  localparam int          HoldCycles     = 300;
  localparam int          StallLimit     = 4000;
  localparam int          ItemTarget     = 1300;

  typedef struct packed {
    logic [7:0] read_data;
    logic       alert_pin;
  } sensor_word_t;

  logic clk_i;
  logic rst_ni;

  tsar_in_if  sensor_in ();
  tsar_out_if sensor_out ();

  temp_sensor_alert_regs i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (sensor_in),
    .out_o (sensor_out)
  );

  sensor_word_t sensor_words_q[$];
  int           err_count;
  int           items_sent;
  bit           tx_calm;
  bit           rx_calm;
  bit           hold_req;
  int           hi_center = 1280;
  int           lo_center = 1200;

  // Local copy of the register and alert state
  ptr_e        m_ptr;
  logic [7:0]  m_cnt;
  logic [7:0]  m_buf [2];
  logic [15:0] m_cfg;
  logic [15:0] m_lo;
  logic [15:0] m_hi;
  logic [12:0] m_temp;
  logic        m_alert;
  logic        m_watch;
  logic [2:0]  m_hcnt;
  logic [2:0]  m_lcnt;

  function automatic void clear_faults();
    m_hcnt = '0;
    m_lcnt = '0;
  endfunction

  function automatic void reset_sensor_state();
    m_ptr   = PTR_TEMP;
    m_cnt   = '0;
    m_buf[0] = '0;
    m_buf[1] = '0;
    m_cfg   = CfgReset;
    m_lo    = LowReset;
    m_hi    = HighReset;
    m_temp  = '0;
    m_alert = 1'b0;
    m_watch = 1'b0;
    clear_faults();
  endfunction

  function automatic logic alert_level();
    return m_alert ^ ~m_cfg[CfgPolBit];
  endfunction

  // Decode a limit register at the format selected right now
  function automatic int limit_sixteenths(logic [15:0] v);
    int x;
    if (m_cfg[CfgEmBit]) x = $signed(v[15:3]);
    else x = $signed(v[15:4]);
    return x;
  endfunction

  function automatic int fault_depth();
    int d;
    case (m_cfg[CfgFqLsb +: 2])
      2'd0: d = 1;
      2'd1: d = 2;
      2'd2: d = 4;
      default: d = 6;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] bump_fault(logic [2:0] cnt, logic hit);
    return hit ? cnt + 3'd1 : 3'd0;
  endfunction

  function automatic void run_alert(logic os_req);
    int depth;
    int t;
    depth = fault_depth();
    t = $signed(m_temp);
    if (m_cfg[CfgSdBit] && !os_req) begin
      clear_faults();
      return;
    end
    if (m_cfg[CfgTmBit]) begin
      if (m_alert) return;
      if (m_watch) begin
        m_hcnt = '0;
        m_lcnt = bump_fault(m_lcnt, t < limit_sixteenths(m_lo));
        if (m_lcnt >= depth) begin
          m_alert = 1'b1;
          m_watch = 1'b0;
          clear_faults();
        end
      end else begin
        m_lcnt = '0;
        m_hcnt = bump_fault(m_hcnt, t >= limit_sixteenths(m_hi));
        if (m_hcnt >= depth) begin
          m_alert = 1'b1;
          m_watch = 1'b1;
          clear_faults();
        end
      end
    end else begin
      if (m_alert) begin
        m_hcnt = '0;
        m_lcnt = bump_fault(m_lcnt, t < limit_sixteenths(m_lo));
        if (m_lcnt >= depth) begin
          m_alert = 1'b0;
          clear_faults();
        end
      end else begin
        m_lcnt = '0;
        m_hcnt = bump_fault(m_hcnt, t >= limit_sixteenths(m_hi));
        if (m_hcnt >= depth) begin
          m_alert = 1'b1;
          clear_faults();
        end
      end
    end
  endfunction

  function automatic void start_read();
    logic [15:0] v;
    m_cnt = '0;
    // interrupt mode: a read clears the pending alert
    if (m_cfg[CfgTmBit]) begin
      m_alert = 1'b0;
      clear_faults();
    end
    case (m_ptr)
      PTR_TEMP: v = m_cfg[CfgEmBit] ? {m_temp, 3'b001} : {m_temp[11:0], 4'b0000};
      PTR_CONFIG: begin
        v = m_cfg;
        v[CfgAlBit] = alert_level();
      end
      PTR_LOW: v = m_lo;
      default: v = m_hi;
    endcase
    m_buf[0] = v[15:8];
    m_buf[1] = v[7:0];
  endfunction

  function automatic void commit_write();
    logic [15:0] v;
    logic [15:0] old;
    logic        os_req;
    v = {m_buf[0], m_buf[1]};
    old = m_cfg;
    os_req = 1'b0;
    case (m_ptr)
      PTR_TEMP: return;
      PTR_CONFIG: begin
        m_cfg = (m_cfg & CfgRoMask) | (v & CfgWrMask);
        if (m_cfg[CfgSdBit] && m_cfg[CfgTmBit] && !old[CfgSdBit]) m_alert = 1'b0;
        os_req = m_cfg[CfgSdBit] && v[CfgOsBit];
      end
      PTR_LOW: m_lo = v;
      default: m_hi = v;
    endcase
    clear_faults();
    if (os_req) run_alert(1'b1);
  endfunction

  function automatic sensor_word_t compute_sensor_word(logic [2:0] mode, logic [11:0] temp,
                                                      logic [7:0] data);
    sensor_word_t w;
    w.read_data = '0;
    case (mode)
      MODE_SAMPLE: begin
        m_temp = {temp[11], temp};
        run_alert(1'b0);
      end
      MODE_START_READ: start_read();
      MODE_BUS_EVENT: m_cnt = '0;
      MODE_WRITE: begin
        if (m_cnt == 8'd0) begin
          m_ptr = ptr_e'(data[1:0]);
        end else begin
          if (m_cnt <= 8'd2) m_buf[m_cnt == 8'd2] = data;
          if (m_cnt == 8'd2) commit_write();
        end
        m_cnt = m_cnt + 8'd1;
      end
      MODE_READ: begin
        if (m_cnt < 8'd2) begin
          w.read_data = m_buf[m_cnt[0]];
          m_cnt = m_cnt + 8'd1;
        end else begin
          w.read_data = ReadPad;
        end
      end
      default: ;
    endcase
    w.alert_pin = alert_level();
    return w;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offer one item from the falling edge and hold it until it is taken
  task automatic send_item(input logic [2:0] mode, input logic [11:0] temp,
                           input logic [7:0] data);
    @(negedge clk_i);
    while (!tx_calm && ($urandom_range(99) < IdlePct)) begin
      sensor_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    sensor_in.valid       <= 1'b1;
    sensor_in.mode        <= mode;
    sensor_in.sample_temp <= temp;
    sensor_in.data_byte   <= data;
    do @(posedge clk_i); while (!sensor_in.ready);
    sensor_words_q.push_back(compute_sensor_word(mode, temp, data));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    sensor_in.valid <= 1'b0;
    while (sensor_words_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input ptr_e p, input logic [15:0] v);
    send_item(MODE_BUS_EVENT, '0, '0);
    send_item(MODE_WRITE, '0, {6'b0, p});
    send_item(MODE_WRITE, '0, v[15:8]);
    send_item(MODE_WRITE, '0, v[7:0]);
  endtask

  task automatic read_reg(input ptr_e p, input bit set_ptr, input int reads);
    if (set_ptr) begin
      send_item(MODE_BUS_EVENT, '0, '0);
      send_item(MODE_WRITE, '0, {6'b0, p});
    end
    send_item(MODE_START_READ, '0, '0);
    repeat (reads) send_item(MODE_READ, '0, '0);
  endtask

  // Most sample centers sit on the programmed limits so the fault queue gets exercised
  function automatic int pick_center();
    int k;
    int c;
    k = $urandom_range(9);
    if (k < 4) c = hi_center;
    else if (k < 8) c = lo_center;
    else c = int'($urandom_range(4095)) - 2048;
    return c + int'($urandom_range(48)) - 24;
  endfunction

  task automatic run_random_sequence();
    int          kind;
    int          n;
    int          base;
    logic [15:0] v;
    ptr_e        p;
    kind = $urandom_range(99);
    if (kind < 35) begin
      // burst of samples close to one level
      n = $urandom_range(8, 1);
      base = pick_center();
      repeat (n) send_item(MODE_SAMPLE, 12'(base + int'($urandom_range(6)) - 3), '0);
    end else if (kind < 50) begin
      v = 16'($urandom);
      if ($urandom_range(3) != 0) v[CfgSdBit] = 1'b0;
      n = $urandom_range(9);
      if (n == 0) v = '0;
      else if (n == 1) v = '1;
      write_reg(PTR_CONFIG, v);
    end else if (kind < 65) begin
      base = int'($urandom_range(4095)) - 2048;
      if (m_cfg[CfgEmBit]) v = {13'(base), 3'($urandom)};
      else v = {12'(base), 4'($urandom)};
      if ($urandom_range(3) == 0) v = 16'($urandom);
      p = ($urandom_range(1) != 0) ? PTR_HIGH : PTR_LOW;
      if (p == PTR_HIGH) hi_center = base;
      else lo_center = base;
      write_reg(p, v);
    end else if (kind < 85) begin
      read_reg(ptr_e'($urandom_range(3)), $urandom_range(2) != 0, $urandom_range(3));
    end else if (kind < 90) begin
      // write that may run past the second data byte
      send_item(MODE_BUS_EVENT, '0, '0);
      send_item(MODE_WRITE, '0, 8'($urandom));
      repeat ($urandom_range(5, 2)) send_item(MODE_WRITE, '0, 8'($urandom));
    end else if (kind < 95) begin
      // write cut short by a bus event
      send_item(MODE_BUS_EVENT, '0, '0);
      send_item(MODE_WRITE, '0, 8'($urandom));
      send_item(MODE_WRITE, '0, 8'($urandom));
      send_item(MODE_BUS_EVENT, '0, '0);
    end else begin
      repeat ($urandom_range(3, 1))
        send_item(3'($urandom_range(ModeSpareLast)), 12'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_directed();
    for (int i = ModeSpareFirst; i <= ModeSpareLast; i++) send_item(3'(i), '1, '1);
    // hottest sample trips the default high limit
    send_item(MODE_SAMPLE, 12'h7FF, '0);
    read_reg(PTR_TEMP, 1'b0, 3);
    send_item(MODE_SAMPLE, 12'h800, '0);
    // every writable config bit plus one-shot while entering shutdown
    write_reg(PTR_CONFIG, 16'hFFFF);
    send_item(MODE_WRITE, '0, 8'h00);
    read_reg(PTR_CONFIG, 1'b0, 2);
    send_item(MODE_SAMPLE, 12'h000, '0);
    write_reg(PTR_TEMP, 16'h1234);
    write_reg(PTR_CONFIG, 16'h0000);
    send_item(MODE_SAMPLE, 12'hFFF, '0);
  endtask

  task automatic test_register_readback();
    ptr_e regs [3] = '{PTR_CONFIG, PTR_LOW, PTR_HIGH};
    foreach (regs[i]) begin
      write_reg(regs[i], 16'hFFFF);
      read_reg(regs[i], 1'b1, 3);
      write_reg(regs[i], 16'h0000);
      read_reg(regs[i], 1'b1, 2);
    end
    read_reg(PTR_TEMP, 1'b1, 2);
    write_reg(PTR_HIGH, HighReset);
    write_reg(PTR_LOW, LowReset);
    hi_center = 1280;
    lo_center = 1200;
  endtask

  task automatic test_byte_wrap();
    send_item(MODE_BUS_EVENT, '0, '0);
    send_item(MODE_WRITE, '0, {6'b0, PTR_LOW});
    send_item(MODE_WRITE, '0, 8'h12);
    send_item(MODE_WRITE, '0, 8'h34);
    // run the byte count round to zero so the next byte is a pointer again
    repeat (253) send_item(MODE_WRITE, '0, 8'($urandom));
    send_item(MODE_WRITE, '0, {6'b0, PTR_HIGH});
    send_item(MODE_WRITE, '0, HighReset[15:8]);
    send_item(MODE_WRITE, '0, HighReset[7:0]);
    read_reg(PTR_HIGH, 1'b1, 3);
    read_reg(PTR_LOW, 1'b1, 2);
    write_reg(PTR_LOW, LowReset);
  endtask

  task automatic test_backpressure();
    int target;
    target = items_sent + 40;
    hold_req = 1'b1;
    while (items_sent < target) run_random_sequence();
    wait_drained();
  endtask

  task automatic test_calm_stretch();
    int target;
    target = items_sent + 150;
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    while (items_sent < target) run_random_sequence();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    while (items_sent < ItemTarget) run_random_sequence();
  endtask

  // Receiver: random ready, with a long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    sensor_out.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        sensor_out.ready <= 1'b0;
        hold_left--;
      end else if (rx_calm) begin
        sensor_out.ready <= 1'b1;
      end else begin
        sensor_out.ready <= ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Compare each result word with the oldest prediction
  initial begin : result_check
    sensor_word_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && sensor_out.valid && sensor_out.ready) begin
        if (sensor_words_q.size() == 0) begin
          $error("unexpected result word: read_data %0h alert_pin %0b",
                 sensor_out.read_data, sensor_out.alert_pin);
          err_count++;
        end else begin
          want = sensor_words_q.pop_front();
          if (sensor_out.read_data !== want.read_data) begin
            $error("read_data: expected %0h, actual %0h", want.read_data, sensor_out.read_data);
            err_count++;
          end
          if (sensor_out.alert_pin !== want.alert_pin) begin
            $error("alert_pin: expected %0b, actual %0b", want.alert_pin, sensor_out.alert_pin);
            err_count++;
          end
        end
      end
    end
  end

  // End the run when nothing moves on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((sensor_in.valid && sensor_in.ready) || (sensor_out.valid && sensor_out.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_temp_sensor_alert_regs: errors");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    sensor_in.valid = 1'b0;
    sensor_in.mode = MODE_SAMPLE;
    sensor_in.sample_temp = '0;
    sensor_in.data_byte = '0;
    err_count = 0;
    items_sent = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    hold_req = 1'b0;
    reset_sensor_state();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_register_readback();
    test_byte_wrap();
    test_backpressure();
    test_calm_stretch();
    test_random_traffic();

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sensor_words_q.size() != 0) begin
      $error("result words never arrived: %0d", sensor_words_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb_temp_sensor_alert_regs: clean");
    end else begin
      $display("tb_temp_sensor_alert_regs: errors");
    end
    $finish;
  end

endmodule
